// ===== hdl/sba_pkg.sv =====
// shared constants, types and helper functions of the segregated bin allocator
`timescale 1ns / 1ps
`default_nettype none

package sba_pkg;

	// sizing
	localparam int PAGE_BYTES   = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int FREE_DEPTH   = 256;
	localparam int BIN_COUNT    = 3;

	localparam int ADDR_W  = 32;
	localparam int SIZE_W  = 32;
	localparam int FILL_W  = $clog2(PAGE_BYTES + 1);
	localparam int CNT_W   = $clog2(FREE_DEPTH + 1);
	localparam int SLOT_W  = $clog2(FREE_DEPTH);
	localparam int MEM_AW  = $clog2(BIN_COUNT * FREE_DEPTH);
	localparam int MEM_DEPTH = BIN_COUNT * FREE_DEPTH;
	localparam int CFG_IDX_W = 8;

	// register reset values
	localparam logic [ADDR_W-1:0] HEAP_START_RST = 32'd65536;
	localparam logic [ADDR_W-1:0] HEAP_END_RST   = 32'd16842752;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END   = 8'd1;

	// request kinds
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_DONE      = 3'd0,
		ST_NULL      = 3'd1,
		ST_LARGE     = 3'd2,
		ST_EXHAUSTED = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		BIN_16    = 2'd0,
		BIN_64    = 2'd1,
		BIN_512   = 2'd2,
		BIN_LARGE = 2'd3
	} bin_t;

	// one port of the stack memory: a write or a read each cycle
	typedef struct packed {
		logic              we;
		logic              re;
		logic [MEM_AW-1:0] addr;
		logic [ADDR_W-1:0] wdata;
	} mem_req_t;

	function automatic bin_t bin_of(input logic [SIZE_W-1:0] size);
		bin_t b;
		if (size <= SIZE_W'(16)) begin
			b = BIN_16;
		end else if (size <= SIZE_W'(64)) begin
			b = BIN_64;
		end else if (size <= SIZE_W'(512)) begin
			b = BIN_512;
		end else begin
			b = BIN_LARGE;
		end
		return b;
	endfunction

	// header plus bin payload
	function automatic logic [FILL_W-1:0] need_of(input bin_t b);
		logic [FILL_W-1:0] n;
		case (b)
			BIN_16:  n = FILL_W'(HEADER_BYTES + 16);
			BIN_64:  n = FILL_W'(HEADER_BYTES + 64);
			BIN_512: n = FILL_W'(HEADER_BYTES + 512);
			default: n = '0;
		endcase
		return n;
	endfunction

	function automatic logic [MEM_AW-1:0] stack_addr(input logic [1:0] b,
		input logic [SLOT_W-1:0] slot);
		return MEM_AW'(b) * MEM_AW'(FREE_DEPTH) + MEM_AW'(slot);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sba_if.sv =====
// request, response and register write channels of the segregated bin allocator
`timescale 1ns / 1ps
`default_nettype none

interface sba_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [sba_pkg::SIZE_W-1:0]  req_size;
	logic [sba_pkg::ADDR_W-1:0]  block_addr;
	logic [sba_pkg::SIZE_W-1:0]  block_size;

	modport source (output valid, req_type, req_size, block_addr, block_size, input ready);
	modport sink (input valid, req_type, req_size, block_addr, block_size, output ready);
endinterface

interface sba_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [sba_pkg::ADDR_W-1:0]  result_addr;
	logic [2:0]                  status;
	logic                        opened_arena;

	modport source (output valid, result_addr, status, opened_arena, input ready);
	modport sink (input valid, result_addr, status, opened_arena, output ready);
endinterface

interface sba_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [sba_pkg::CFG_IDX_W-1:0] reg_index;
	logic [sba_pkg::ADDR_W-1:0]    wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== hdl/segregated_bin_allocator_core.sv =====
// top level of the segregated bin allocator: control, arena state and result register
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | handshake   | payload
// req     | in  | valid/ready | req_type, req_size, block_addr, block_size
// rsp     | out | valid/ready | result_addr, status, opened_arena
// cfg     | in  | valid/ready | reg_index, wdata (0 heap_start, 1 heap_end)
//
// a request passes through accept and execute; a pop from a free stack adds a pop
// step, which takes the registered read data of the stack memory port
// the next request is taken once the current one has reached the result register
// reset clears counts and arena state and restores heap top and heap end; stack contents are not cleared
// a held result stalls the pop step and any execute step that starts no pop, not the acceptance of a request
// cfg is always ready; writes are expected while no request is in flight

module segregated_bin_allocator_core (
	input  logic         clk,
	input  logic         arst_n,
	sba_req_if.sink      req,
	sba_rsp_if.source    rsp,
	sba_cfg_if.sink      cfg
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_POP  = 3'b100
	} state_t;

	state_t state_q;

	// request held for execution
	logic                       req_type_s1;
	logic [sba_pkg::SIZE_W-1:0] req_size_s1;
	logic [sba_pkg::ADDR_W-1:0] block_addr_s1;
	logic [sba_pkg::SIZE_W-1:0] block_size_s1;

	// allocator state
	logic [sba_pkg::CNT_W-1:0]  cnt_q [sba_pkg::BIN_COUNT];
	logic                       arena_valid_q;
	logic [sba_pkg::ADDR_W-1:0] arena_base_q;
	logic [sba_pkg::FILL_W-1:0] fill_q;
	logic [sba_pkg::ADDR_W-1:0] heap_top_q;
	logic [sba_pkg::ADDR_W-1:0] heap_end_q;

	// result register
	logic                       out_valid_q;
	logic [sba_pkg::ADDR_W-1:0] out_addr_q;
	sba_pkg::status_t           out_status_q;
	logic                       out_opened_q;

	// execute-step decode
	sba_pkg::bin_t              bin;
	logic [sba_pkg::CNT_W-1:0]  cnt_sel;
	logic [sba_pkg::FILL_W-1:0] need;
	logic                       fits;
	logic                       room;
	logic [sba_pkg::ADDR_W-1:0] bump_addr;
	logic                       out_free;
	logic                       out_load;
	logic                       req_acc;
	logic                       cfg_acc;
	logic                       do_pop;
	logic                       do_push;
	logic                       bump_ok;
	logic [sba_pkg::ADDR_W-1:0] res_addr;
	sba_pkg::status_t           res_status;
	logic                       res_opened;
	sba_pkg::mem_req_t          mem_req;
	logic [sba_pkg::ADDR_W-1:0] rd_data;

	assign req_acc  = req.valid && req.ready;
	assign cfg_acc  = cfg.valid && cfg.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out_free = !out_valid_q || rsp.ready;

	// bin comes from the requested size or from the freed block's header size
	assign bin = sba_pkg::bin_of((req_type_s1 == sba_pkg::REQ_FREE) ? block_size_s1 : req_size_s1);
	assign need = sba_pkg::need_of(bin);

	always_comb begin
		case (bin)
			sba_pkg::BIN_16:  cnt_sel = cnt_q[0];
			sba_pkg::BIN_64:  cnt_sel = cnt_q[1];
			sba_pkg::BIN_512: cnt_sel = cnt_q[2];
			default:          cnt_sel = '0;
		endcase
	end

	// current arena has room for header plus bin
	assign fits = arena_valid_q &&
		(({1'b0, fill_q} + {1'b0, need}) <= (sba_pkg::FILL_W + 1)'(sba_pkg::PAGE_BYTES));
	// a fresh page fits below heap end, no wrap
	assign room = ({1'b0, heap_top_q} + 33'(sba_pkg::PAGE_BYTES)) <= {1'b0, heap_end_q};
	// user address: block start plus header; a fresh arena starts after its own header
	assign bump_addr = fits
		? arena_base_q + sba_pkg::ADDR_W'(fill_q) + sba_pkg::ADDR_W'(sba_pkg::HEADER_BYTES)
		: heap_top_q + sba_pkg::ADDR_W'(2 * sba_pkg::HEADER_BYTES);

	// pop needs no free result slot yet, push commits only with the result
	assign do_pop = (state_q == S_EXEC) && (req_type_s1 == sba_pkg::REQ_ALLOC) &&
		(req_size_s1 != '0) && (bin != sba_pkg::BIN_LARGE) && (cnt_sel != '0);
	assign do_push = (state_q == S_EXEC) && (req_type_s1 == sba_pkg::REQ_FREE) &&
		(block_addr_s1 != '0) && (bin != sba_pkg::BIN_LARGE) &&
		(cnt_sel < sba_pkg::CNT_W'(sba_pkg::FREE_DEPTH)) && out_free;

	// result register loads at the end of execute or pop
	assign out_load = out_free &&
		(((state_q == S_EXEC) && !do_pop) || (state_q == S_POP));

	// outcome of a request that needs no stack read
	always_comb begin
		res_addr   = '0;
		res_status = sba_pkg::ST_DONE;
		res_opened = 1'b0;
		bump_ok    = 1'b0;
		if (req_type_s1 == sba_pkg::REQ_ALLOC) begin
			if (req_size_s1 == '0) begin
				res_status = sba_pkg::ST_NULL;
			end else if (bin == sba_pkg::BIN_LARGE) begin
				res_status = sba_pkg::ST_LARGE;
			end else if (!fits && !room) begin
				res_status = sba_pkg::ST_EXHAUSTED;
			end else begin
				res_addr   = bump_addr;
				res_opened = !fits;
				bump_ok    = 1'b1;
			end
		end else begin
			if (block_addr_s1 == '0) begin
				res_status = sba_pkg::ST_NULL;
			end else if (bin == sba_pkg::BIN_LARGE) begin
				res_status = sba_pkg::ST_LARGE;
			end else if (!(cnt_sel < sba_pkg::CNT_W'(sba_pkg::FREE_DEPTH))) begin
				res_status = sba_pkg::ST_FULL;
			end
		end
	end

	always_comb begin
		mem_req.we    = do_push;
		mem_req.re    = do_pop;
		mem_req.wdata = block_addr_s1;
		if (do_push) begin
			mem_req.addr = sba_pkg::stack_addr(bin, sba_pkg::SLOT_W'(cnt_sel));
		end else begin
			mem_req.addr = sba_pkg::stack_addr(bin, sba_pkg::SLOT_W'(cnt_sel - 1'b1));
		end
	end

	sba_stack_mem u_stack_mem (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	// request capture
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_type_s1   <= req.req_type;
			req_size_s1   <= req.req_size;
			block_addr_s1 <= req.block_addr;
			block_size_s1 <= req.block_size;
		end
	end

	// control, allocator state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '{default: '0};
			arena_valid_q <= 1'b0;
			arena_base_q  <= '0;
			fill_q        <= '0;
			heap_top_q    <= sba_pkg::HEAP_START_RST;
			heap_end_q    <= sba_pkg::HEAP_END_RST;
			out_valid_q   <= 1'b0;
			out_addr_q    <= '0;
			out_status_q  <= sba_pkg::ST_DONE;
			out_opened_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (do_pop) begin
						// read of the top entry is under way
						cnt_q[bin[1:0]] <= cnt_sel - 1'b1;
						state_q         <= S_POP;
					end else if (out_free) begin
						out_addr_q   <= res_addr;
						out_opened_q <= res_opened;
						out_status_q <= res_status;
						state_q      <= S_IDLE;
						if (bump_ok) begin
							if (fits) begin
								fill_q <= fill_q + need;
							end else begin
								// open a new page arena at the heap top
								arena_base_q  <= heap_top_q;
								heap_top_q    <= heap_top_q +
									sba_pkg::ADDR_W'(sba_pkg::PAGE_BYTES);
								fill_q        <= sba_pkg::FILL_W'(sba_pkg::HEADER_BYTES) + need;
								arena_valid_q <= 1'b1;
							end
						end
						if (do_push) begin
							cnt_q[bin[1:0]] <= cnt_sel + 1'b1;
						end
					end
				end
				S_POP: begin
					if (out_free) begin
						out_addr_q   <= rd_data;
						out_status_q <= sba_pkg::ST_DONE;
						out_opened_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// register writes; rebasing restarts the heap and drops the arena
			if (cfg_acc) begin
				case (cfg.reg_index)
					sba_pkg::CFG_HEAP_START: begin
						heap_top_q    <= cfg.wdata;
						arena_valid_q <= 1'b0;
					end
					sba_pkg::CFG_HEAP_END: begin
						heap_end_q <= cfg.wdata;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_addr  = out_addr_q;
	assign rsp.status       = out_status_q;
	assign rsp.opened_arena = out_opened_q;

	// stack counts move only in the execute step
	a_cnt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_EXEC |=> $stable(cnt_q[0]) && $stable(cnt_q[1]) && $stable(cnt_q[2]))
		else $error("stack count changed outside execute");

	// an accepted request goes straight to execute
	a_acc_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> state_q == S_EXEC)
		else $error("accepted request did not reach execute");

	// a result appears only at the end of execute or pop
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_EXEC || $past(state_q) == S_POP)
		else $error("result raised from wrong state");

	// pop follows execute, waiting only on the result register
	a_pop_src: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> $past(state_q) == S_EXEC || $past(state_q) == S_POP)
		else $error("pop entered from wrong state");

	// an opened arena is a successful allocation that leaves the arena valid
	a_opened: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_opened_q |-> out_status_q == sba_pkg::ST_DONE && arena_valid_q)
		else $error("opened arena with bad status");

endmodule

`default_nettype wire

// ===== hdl/sba_stack_mem.sv =====
// free stack storage: one synchronous port, write or registered read
`timescale 1ns / 1ps
`default_nettype none

module sba_stack_mem (
	input  logic                       clk,
	input  sba_pkg::mem_req_t          mem_req,
	output logic [sba_pkg::ADDR_W-1:0] rd_data
);

	logic [sba_pkg::ADDR_W-1:0] mem [sba_pkg::MEM_DEPTH];
	logic [sba_pkg::ADDR_W-1:0] rd_data_q;

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.addr] <= mem_req.wdata;
		end
		if (mem_req.re) begin
			rd_data_q <= mem[mem_req.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== tb/sba_heap_checker.sv =====
// request/result checker for the segregated bin allocator: heap predictor and result comparison
`timescale 1ns / 1ps

module sba_heap_checker
	import sba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sba_req_if          req,
	sba_rsp_if          rsp,
	sba_cfg_if          cfg,
	output int unsigned pending,
	output int unsigned faults,
	output int unsigned checked
);

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           status;
		logic              opened;
	} alloc_result_t;

	alloc_result_t     awaited_q[$];

	// predicted heap state
	logic [ADDR_W-1:0] heap_limit_r;
	logic [ADDR_W-1:0] heap_top_r;
	logic [ADDR_W-1:0] arena_base_r;
	logic              arena_open_r;
	int unsigned       arena_used_r;
	logic [ADDR_W-1:0] free_list [BIN_COUNT][FREE_DEPTH];
	int unsigned       free_cnt [BIN_COUNT];

	// bins hold 16, 64 and 512 byte payloads
	function automatic bin_t size_class(input logic [SIZE_W-1:0] bytes);
		if (bytes <= 32'd16) return BIN_16;
		if (bytes <= 32'd64) return BIN_64;
		if (bytes <= 32'd512) return BIN_512;
		return BIN_LARGE;
	endfunction

	function automatic int unsigned payload_of(input bin_t b);
		case (b)
			BIN_16:  return 16;
			BIN_64:  return 64;
			default: return 512;
		endcase
	endfunction

	function automatic alloc_result_t serve_request(input logic kind,
		input logic [SIZE_W-1:0] size, input logic [ADDR_W-1:0] baddr,
		input logic [SIZE_W-1:0] bsize);
		alloc_result_t r;
		bin_t          b;
		int unsigned   need;
		logic [ADDR_W:0] span;
		r.addr   = '0;
		r.status = ST_DONE;
		r.opened = 1'b0;
		if (kind == REQ_ALLOC) begin
			b = size_class(size);
			if (size == '0) begin
				r.status = ST_NULL;
			end else if (b == BIN_LARGE) begin
				r.status = ST_LARGE;
			end else if (free_cnt[b] > 0) begin
				// lifo reuse of a freed block
				free_cnt[b] = free_cnt[b] - 1;
				r.addr = free_list[b][free_cnt[b]];
			end else begin
				need = HEADER_BYTES + payload_of(b);
				if (!arena_open_r || arena_used_r + need > PAGE_BYTES) begin
					span = {1'b0, heap_top_r} + (ADDR_W+1)'(PAGE_BYTES);
					if (span > {1'b0, heap_limit_r}) begin
						r.status = ST_EXHAUSTED;
					end else begin
						arena_base_r = heap_top_r;
						heap_top_r   = span[ADDR_W-1:0];
						arena_used_r = HEADER_BYTES;
						arena_open_r = 1'b1;
						r.opened     = 1'b1;
					end
				end
				if (r.status == ST_DONE) begin
					r.addr = arena_base_r + ADDR_W'(arena_used_r) + ADDR_W'(HEADER_BYTES);
					arena_used_r = arena_used_r + need;
				end
			end
		end else if (baddr == '0) begin
			r.status = ST_NULL;
		end else begin
			b = size_class(bsize);
			if (b == BIN_LARGE) begin
				r.status = ST_LARGE;
			end else if (free_cnt[b] >= FREE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				free_list[b][free_cnt[b]] = baddr;
				free_cnt[b] = free_cnt[b] + 1;
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [ADDR_W-1:0] want,
		input logic [ADDR_W-1:0] got);
		if (got !== want) begin
			faults = faults + 1;
			$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			awaited_q.delete();
			heap_limit_r = HEAP_END_RST;
			heap_top_r   = HEAP_START_RST;
			arena_base_r = '0;
			arena_open_r = 1'b0;
			arena_used_r = 0;
			foreach (free_cnt[i]) free_cnt[i] = 0;
			faults  = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.reg_index == CFG_HEAP_START) begin
					// rebase: stacks survive, arena is dropped
					heap_top_r   = cfg.wdata;
					arena_open_r = 1'b0;
				end else if (cfg.reg_index == CFG_HEAP_END) begin
					heap_limit_r = cfg.wdata;
				end
			end
			if (req.valid && req.ready) begin
				awaited_q.push_back(serve_request(req.req_type, req.req_size,
					req.block_addr, req.block_size));
			end
			if (rsp.valid && rsp.ready) begin
				checked = checked + 1;
				if (awaited_q.size() == 0) begin
					faults = faults + 1;
					$display("%0t: result with none outstanding, expected nothing actual %h/%0d/%0d",
						$time, rsp.result_addr, rsp.status, rsp.opened_arena);
				end else begin
					want = awaited_q.pop_front();
					check_field("result_addr", want.addr, rsp.result_addr);
					check_field("status", ADDR_W'(want.status), ADDR_W'(rsp.status));
					check_field("opened_arena", ADDR_W'(want.opened), ADDR_W'(rsp.opened_arena));
				end
			end
			pending <= awaited_q.size();
		end
	end

endmodule

// ===== tb/segregated_bin_allocator_core_tb.sv =====
// top of the segregated bin allocator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module segregated_bin_allocator_core_tb;
	import sba_pkg::*;

	// no request, result or register write for this long means a hang
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// cycles left to settle once nothing is outstanding
	localparam int unsigned END_SETTLE     = 8;
	// register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 8'hFF;

	logic        clk;
	logic        arst_n;
	logic        calm;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned sent = 0;
	int unsigned settings = 1;
	int unsigned pending;
	int unsigned faults;
	int unsigned checked;

	sba_req_if req_ch ();
	sba_rsp_if rsp_ch ();
	sba_cfg_if cfg_ch ();

	segregated_bin_allocator_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	sba_heap_checker heap_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.cfg     (cfg_ch),
		.pending (pending),
		.faults  (faults),
		.checked (checked)
	);

	// 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// result side back-pressure: random stall bursts, none once calm
	always @(posedge clk) begin
		if (stall_left != 0 && !calm) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 6) == 0) begin
			stall_left <= $urandom_range(1, 9) - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			stall_left <= 0;
			rsp_ch.ready <= 1'b1;
		end
	end

	// hang detector: counts cycles with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, pending);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one request; valid is left high so back-to-back requests need no re-raise
	task automatic push_request(input logic kind, input logic [SIZE_W-1:0] size,
		input logic [ADDR_W-1:0] baddr, input logic [SIZE_W-1:0] bsize);
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.req_size   <= size;
		req_ch.block_addr <= baddr;
		req_ch.block_size <= bsize;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sent++;
		// sender gap burst
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// rebase the heap while idle; a write to an unmapped index rides along
	task automatic set_heap(input logic [ADDR_W-1:0] start_v, input logic [ADDR_W-1:0] end_v,
		input logic [CFG_IDX_W-1:0] spare_idx);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [ADDR_W-1:0]    val [3];
		idx = '{CFG_HEAP_START, CFG_HEAP_END, spare_idx};
		val = '{start_v, end_v, $urandom};
		drain();
		foreach (idx[i]) begin
			cfg_ch.valid     <= 1'b1;
			cfg_ch.reg_index <= idx[i];
			cfg_ch.wdata     <= val[i];
			@(posedge clk);
			while (!cfg_ch.ready) @(posedge clk);
		end
		cfg_ch.valid <= 1'b0;
		settings++;
	endtask

	// size inside a bin; lean selects a favoured bin, BIN_LARGE means no favourite
	function automatic logic [SIZE_W-1:0] pick_size(input bin_t lean);
		bin_t b;
		if (lean != BIN_LARGE && $urandom_range(0, 99) < 75) begin
			b = lean;
		end else begin
			b = bin_t'($urandom_range(0, 2));
		end
		case (b)
			BIN_16:  return $urandom_range(1, 16);
			BIN_64:  return $urandom_range(17, 64);
			default: return $urandom_range(65, 512);
		endcase
	endfunction

	// mostly well-formed allocate/free traffic with a sprinkling of null and oversize noise
	task automatic issue_mix(input int unsigned count, input int unsigned alloc_pct,
		input bin_t lean);
		logic              kind;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] baddr;
		logic [SIZE_W-1:0] bsize;
		repeat (count) begin
			kind  = ($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_FREE;
			// the field the request kind ignores carries random bits
			size  = (kind == REQ_ALLOC) ? pick_size(lean) : $urandom;
			bsize = (kind == REQ_FREE) ? pick_size(lean) : $urandom;
			baddr = $urandom;
			if ($urandom_range(0, 99) < 6) begin
				case ($urandom_range(0, 2))
					0: begin
						size  = '0;
						baddr = '0;
					end
					1: begin
						size  = $urandom_range(513, 32'hFFFF_FFFF);
						bsize = $urandom_range(513, 32'hFFFF_FFFF);
					end
					default: bsize = '0;
				endcase
			end
			push_request(kind, size, baddr, bsize);
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		calm              <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= REQ_ALLOC;
		req_ch.req_size   <= '0;
		req_ch.block_addr <= '0;
		req_ch.block_size <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.reg_index  <= CFG_HEAP_START;
		cfg_ch.wdata      <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests on the reset heap
		push_request(REQ_ALLOC, 32'd0, 32'hDEAD_BEEF, 32'd16);         // zero size is null
		push_request(REQ_ALLOC, 32'hFFFF_FFFF, '0, '0);                // oversize goes to the os
		push_request(REQ_ALLOC, 32'd1, '0, '0);                        // first arena opens
		push_request(REQ_ALLOC, 32'd16, '0, '0);
		push_request(REQ_ALLOC, 32'd17, '0, '0);
		push_request(REQ_ALLOC, 32'd64, '0, '0);
		push_request(REQ_ALLOC, 32'd65, '0, '0);
		push_request(REQ_ALLOC, 32'd512, '0, '0);
		push_request(REQ_FREE, 32'd8, 32'd0, 32'd16);                  // null pointer free
		push_request(REQ_FREE, '0, 32'h0004_0000, 32'd513);            // oversize header
		push_request(REQ_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_request(REQ_FREE, '0, 32'h0000_1234, 32'd0);              // empty header -> 16 bin
		push_request(REQ_FREE, '0, 32'hFFFF_FFF0, 32'd16);
		push_request(REQ_FREE, '0, 32'h8000_0000, 32'd64);
		push_request(REQ_FREE, '0, 32'h0000_0001, 32'd512);
		push_request(REQ_ALLOC, 32'd8, '0, '0);                        // pops in lifo order
		push_request(REQ_ALLOC, 32'd10, '0, '0);
		push_request(REQ_ALLOC, 32'd40, '0, '0);
		push_request(REQ_ALLOC, 32'd300, '0, '0);
		// big blocks until the arena overflows and a second one opens
		repeat (6) push_request(REQ_ALLOC, 32'd512, '0, '0);

		// mixed traffic on the reset heap
		issue_mix(350, 50, BIN_LARGE);
		// two-page heap: quickly exhausted
		set_heap(32'h0000_1000, 32'h0000_3000, CFG_SPARE_LO);
		issue_mix(250, 80, BIN_512);
		// free-heavy on the small bin to overflow its stack
		set_heap(32'h0010_0000, HEAP_END_RST, CFG_SPARE_HI);
		issue_mix(400, 8, BIN_16);
		// arena at the very top of the address space, stacks drained
		set_heap(32'hFFFF_E000, 32'hFFFF_FFFF, CFG_SPARE_LO);
		issue_mix(400, 90, BIN_LARGE);
		// no arena can ever fit
		set_heap(32'hFFFF_FFFF, 32'h0000_0000, CFG_SPARE_HI);
		issue_mix(100, 70, BIN_LARGE);
		// whole address space, no idling on either side
		set_heap(32'h0000_0000, 32'hFFFF_FFFF, CFG_SPARE_LO);
		calm <= 1'b1;
		issue_mix(300, 50, BIN_LARGE);

		drain();
		repeat (END_SETTLE) @(posedge clk);
		$display("covered %0d requests, %0d results checked, over %0d heap settings",
			sent, checked, settings);
		$display("null, oversize, exhausted heap, full stack and rebasing all exercised");
		if (faults == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
